FILE: rtl/core/bfdh_pkg.sv
`timescale 1ns / 1ps

package bfdh_pkg;

  // Filter geometry
  localparam int MAX_FILTER_BITS_DEF = 65536;
  localparam int MIN_BYTES           = 8;
  localparam int ROW_W               = 32;
  localparam int ROW_BITS            = 5;

  // Probe count limits
  localparam int PROBE_W    = 5;
  localparam int MAX_PROBES = 30;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 14;
  localparam int BYTES_W    = 14;
  localparam int BYTES_RST  = 8192;
  localparam int PROBES_RST = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PROBES   = 8'd1;

  // Commands
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Key and remainder unit
  localparam int KEY_W          = 32;
  localparam int ROT            = 17;
  localparam int DIV_STEP_BITS  = 4;
  localparam int DIV_CYCLES     = KEY_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/bloom_filter_double_hash.sv
`timescale 1ns / 1ps

// Bloom filter with double hashing over an internal bit array.
// Command channel: an item (in_opcode, in_key_hash) is taken when start is
// high and busy is low. Insert sets k bit positions, query tests them, clear
// zeroes the array. Every item gives exactly one result, shown for one cycle
// on out_may_match with out_valid high; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; register 0
// is filter_bytes, register 1 is num_probes. cfg_ready is always high.
// Each probe reduces the running hash modulo the filter size in a shared
// remainder unit that retires 4 dividend bits a cycle, then reads one 32-bit
// row of the array and checks or sets the bit. An insert or query gives its
// result after its last probe; a query ends early at the first clear bit.
// A clear writes one row per cycle and gives its result once the last row
// is written, and opcode 3 answers 0. After reset the block runs the same
// clearing pass, without a result, and holds busy high until the pass ends.
// Reset also loads filter_bytes = 8192 and num_probes = 6.
module bloom_filter_double_hash #(
  parameter int MAX_FILTER_BITS = bfdh_pkg::MAX_FILTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bfdh_pkg::OP_W-1:0]       in_opcode,
  input  logic [bfdh_pkg::KEY_W-1:0]      in_key_hash,
  output logic                            out_valid,
  output logic                            out_may_match,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAX_BYTES = MAX_FILTER_BITS / 8;
  localparam int BW        = $clog2(MAX_BYTES + 1);
  localparam int PW        = BW + 3;
  localparam int ROWS      = (MAX_FILTER_BITS + bfdh_pkg::ROW_W - 1) / bfdh_pkg::ROW_W;
  localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW        = bfdh_pkg::KEY_W;

  bfdh_pkg::state_t state_r, state_nxt;

  logic [bfdh_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [KW-1:0]                h_r, h_nxt;
  logic [KW-1:0]                delta_r, delta_nxt;
  logic [bfdh_pkg::PROBE_W-1:0] k_r, k_nxt;
  logic [bfdh_pkg::PROBE_W-1:0] probe_cnt_r, probe_cnt_nxt;
  logic [BW-1:0]                b_r, b_nxt;
  logic [KW-1:0]                dvd_r, dvd_nxt;
  logic [BW-1:0]                rem_r, rem_nxt;
  logic [bfdh_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic                         clr_report_r, clr_report_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_match_r, out_match_nxt;

  logic [bfdh_pkg::BYTES_W-1:0] cfg_bytes_r;
  logic [bfdh_pkg::PROBE_W-1:0] cfg_probes_r;

  logic [bfdh_pkg::ROW_W-1:0] mem [ROWS];
  logic [bfdh_pkg::ROW_W-1:0] rd_data_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [bfdh_pkg::ROW_W-1:0] mem_wd;

  logic [AW-1:0]              row_addr;
  logic [bfdh_pkg::ROW_W-1:0] bit_mask;
  logic                       bit_set;
  logic [BW-1:0]              rem_step;
  logic [KW-1:0]              dvd_step;
  logic [KW-1:0]              h_sum;
  logic [BW-1:0]              b_clamp;
  logic [bfdh_pkg::PROBE_W-1:0] k_clamp;

  assign busy          = (state_r != bfdh_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_may_match = out_match_r;
  assign cfg_ready     = 1'b1;

  assign row_addr = AW'(pos_r >> bfdh_pkg::ROW_BITS);
  assign bit_mask = bfdh_pkg::ROW_W'(1) << pos_r[bfdh_pkg::ROW_BITS-1:0];
  assign bit_set  = |(rd_data_r & bit_mask);
  assign h_sum    = h_r + delta_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bytes_r  <= bfdh_pkg::BYTES_W'(bfdh_pkg::BYTES_RST);
      cfg_probes_r <= bfdh_pkg::PROBE_W'(bfdh_pkg::PROBES_RST);
    end else if (cfg_valid) begin
      if (cfg_index == bfdh_pkg::REG_FILTER_BYTES) begin
        cfg_bytes_r <= cfg_data[bfdh_pkg::BYTES_W-1:0];
      end else if (cfg_index == bfdh_pkg::REG_NUM_PROBES) begin
        cfg_probes_r <= cfg_data[bfdh_pkg::PROBE_W-1:0];
      end
    end
  end

  // Size and probe count are clamped into their legal ranges.
  always_comb begin
    if (32'(cfg_bytes_r) < bfdh_pkg::MIN_BYTES) begin
      b_clamp = BW'(bfdh_pkg::MIN_BYTES);
    end else if (32'(cfg_bytes_r) > MAX_BYTES) begin
      b_clamp = BW'(MAX_BYTES);
    end else begin
      b_clamp = BW'(cfg_bytes_r);
    end
    if (cfg_probes_r == '0) begin
      k_clamp = bfdh_pkg::PROBE_W'(1);
    end else if (32'(cfg_probes_r) > bfdh_pkg::MAX_PROBES) begin
      k_clamp = bfdh_pkg::PROBE_W'(bfdh_pkg::MAX_PROBES);
    end else begin
      k_clamp = cfg_probes_r;
    end
  end

  // Shared remainder unit: restoring division of (h >> 3) by the byte count,
  // a few bits per cycle. Since m = 8 * bytes, h mod m is the remainder
  // followed by the low three bits of h.
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] r;
    logic [KW-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int i = 0; i < bfdh_pkg::DIV_STEP_BITS; i++) begin
      t = {r, d[KW-1]};
      d = d << 1;
      if (t >= {1'b0, b_r}) begin
        t = t - {1'b0, b_r};
      end
      r = t[BW-1:0];
    end
    rem_step = r;
    dvd_step = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfdh_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    h_r         <= h_nxt;
    delta_r     <= delta_nxt;
    k_r         <= k_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    b_r         <= b_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    pos_r       <= pos_nxt;
    out_match_r <= out_match_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    h_nxt          = h_r;
    delta_nxt      = delta_r;
    k_nxt          = k_r;
    probe_cnt_nxt  = probe_cnt_r;
    b_nxt          = b_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    pos_nxt        = pos_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    out_valid_nxt  = 1'b0;
    out_match_nxt  = out_match_r;
    mem_we         = 1'b0;
    mem_wa         = row_addr;
    mem_wd         = rd_data_r | bit_mask;

    unique case (state_r)
      bfdh_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
        if (clr_cnt_r == AW'(ROWS - 1)) begin
          state_nxt     = bfdh_pkg::ST_IDLE;
          out_valid_nxt = clr_report_r;
          out_match_nxt = 1'b0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      bfdh_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt        = in_opcode;
          h_nxt         = in_key_hash;
          delta_nxt     = {in_key_hash[bfdh_pkg::ROT-1:0], in_key_hash[KW-1:bfdh_pkg::ROT]};
          k_nxt         = k_clamp;
          b_nxt         = b_clamp;
          probe_cnt_nxt = '0;
          if (in_opcode == bfdh_pkg::OP_INSERT || in_opcode == bfdh_pkg::OP_QUERY) begin
            state_nxt   = bfdh_pkg::ST_DIV;
            dvd_nxt     = in_key_hash >> 3;
            rem_nxt     = '0;
            div_cnt_nxt = '0;
          end else if (in_opcode == bfdh_pkg::OP_CLEAR) begin
            state_nxt      = bfdh_pkg::ST_CLEAR;
            clr_cnt_nxt    = '0;
            clr_report_nxt = 1'b1;
          end else begin
            state_nxt = bfdh_pkg::ST_DONE;
          end
        end
      end
      bfdh_pkg::ST_DIV: begin
        rem_nxt     = rem_step;
        dvd_nxt     = dvd_step;
        div_cnt_nxt = div_cnt_r + bfdh_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_CYCLES - 1)) begin
          state_nxt = bfdh_pkg::ST_READ;
          pos_nxt   = {rem_step, h_r[2:0]};
        end
      end
      bfdh_pkg::ST_READ: begin
        state_nxt = bfdh_pkg::ST_CHECK;
      end
      bfdh_pkg::ST_CHECK: begin
        mem_we = (op_r == bfdh_pkg::OP_INSERT);
        if (op_r == bfdh_pkg::OP_QUERY && !bit_set) begin
          state_nxt     = bfdh_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_match_nxt = 1'b0;
        end else if (probe_cnt_r == k_r - bfdh_pkg::PROBE_W'(1)) begin
          state_nxt     = bfdh_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_match_nxt = (op_r == bfdh_pkg::OP_QUERY);
        end else begin
          state_nxt     = bfdh_pkg::ST_DIV;
          probe_cnt_nxt = probe_cnt_r + bfdh_pkg::PROBE_W'(1);
          h_nxt         = h_sum;
          dvd_nxt       = h_sum >> 3;
          rem_nxt       = '0;
          div_cnt_nxt   = '0;
        end
      end
      bfdh_pkg::ST_DONE: begin
        state_nxt     = bfdh_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_match_nxt = 1'b0;
      end
      default: begin
        state_nxt = bfdh_pkg::ST_IDLE;
      end
    endcase
  end

  // Bit array, one 32-bit row per entry, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[row_addr];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_may_match) |-> (op_r == bfdh_pkg::OP_QUERY))
    else $error("match reported for a command other than query");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfdh_pkg::ST_CHECK) |-> (probe_cnt_r < k_r))
    else $error("probe count ran past the configured number");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfdh_pkg::ST_READ) |-> (pos_r[PW-1:3] < b_r))
    else $error("probe position outside the filter");

endmodule
